// ===== sv/gbr_pkg.sv =====
`default_nettype none

package gbr_pkg;

   // fixed field widths
   localparam int POS_W  = 8;
   localparam int PIX_W  = 16;
   localparam int WGT_W  = 16;
   localparam int PROD_W = PIX_W + WGT_W;
   localparam int DIM_W  = 9;
   localparam int RAD_W  = 2;
   localparam int TYPE_W = 2;

   // configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // saturation limit of a result
   localparam logic [PIX_W-1:0] SAT_MAX = '1;

   // register reset values
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;
   localparam logic [RAD_W-1:0] RADIUS_RST       = 2'd1;

   // request codes
   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD_WEIGHT = 2'd0,
      REQ_LOAD_PIXEL  = 2'd1,
      REQ_COMPUTE     = 2'd2
   } gbr_req_type;

   // register indexes (byte address bits [3:2])
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_KERNEL_RADIUS = 2'd2
   } gbr_csr_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_FINISH
   } gbr_state_type;

endpackage

`default_nettype wire

// ===== sv/gbr_req_if.sv =====
`default_nettype none

interface gbr_req_if;
   logic                         valid;
   logic                         ready;
   logic [gbr_pkg::TYPE_W-1:0]   req_type;
   logic [gbr_pkg::POS_W-1:0]    pos_x;
   logic [gbr_pkg::POS_W-1:0]    pos_y;
   logic [gbr_pkg::PIX_W-1:0]    value;

   modport source (output valid, req_type, pos_x, pos_y, value, input ready);
   modport sink   (input valid, req_type, pos_x, pos_y, value, output ready);
endinterface

`default_nettype wire

// ===== sv/gbr_rsp_if.sv =====
`default_nettype none

interface gbr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gbr_pkg::PIX_W-1:0]  filtered_pixel;

   modport source (output valid, filtered_pixel, input ready);
   modport sink   (input valid, filtered_pixel, output ready);
endinterface

`default_nettype wire

// ===== sv/gbr_pixel_mem.sv =====
`default_nettype none

module gbr_pixel_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [gbr_pkg::PIX_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [gbr_pkg::PIX_W-1:0] rd_data
);

   logic [gbr_pkg::PIX_W-1:0] mem_ff [DEPTH];
   logic [gbr_pkg::PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/gbr_kernel_mem.sv =====
`default_nettype none

module gbr_kernel_mem #(
   parameter int DEPTH = 49,
   parameter int AW    = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [gbr_pkg::WGT_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [gbr_pkg::WGT_W-1:0] rd_data
);

   logic [gbr_pkg::WGT_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]          valid_ff;
   logic [gbr_pkg::WGT_W-1:0] rd_data_ff;
   logic                      rd_valid_ff;

   // weight storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // per-entry written flags, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== sv/gbr_divider.sv =====
`default_nettype none

module gbr_divider #(
   parameter int ACC_W = 38,
   parameter int SUM_W = 22
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ACC_W-1:0]          dividend,
   input  wire logic [SUM_W-1:0]          divisor,
   output logic                           done,
   output logic      [gbr_pkg::PIX_W-1:0] quotient
);

   localparam int QW = gbr_pkg::PIX_W;
   localparam int CW = $clog2(QW);

   logic [ACC_W-1:0] rem_ff;
   logic [ACC_W-1:0] den_ff;
   logic [QW-1:0]    quot_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             fits;

   // dividend stays below divisor * 2^16, so one quotient bit per step
   assign fits = (rem_ff >= den_ff);

   // restoring division datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         den_ff  <= ACC_W'(divisor) << (QW - 1);
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - den_ff;
         end
         quot_ff <= {quot_ff[QW-2:0], fits};
         den_ff  <= den_ff >> 1;
      end
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ===== sv/gaussian_blur_border_renorm_unit.sv =====
// Flow: a load transaction writes its memory on acceptance; a compute transaction inside
// the frame scans its (2r+1)^2 taps, drains the pipeline, divides for a border pixel.
// Throughput: one transaction at a time; the tap scan reads one weight per cycle and each
// in-frame pixel; a border pixel with a nonzero weight sum runs a 16-step divider.
// Reset: registers return to 256 x 256, radius 1; kernel weights read as zero at once
// (per-entry written flags); the pixel store is not cleared and needs no clearing pass.
`default_nettype none

module gaussian_blur_border_renorm_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   gbr_req_if.sink                          req_chan,
   gbr_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [gbr_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [gbr_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [gbr_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int KDIM  = 2 * MAX_RADIUS + 1;
   localparam int TAPS  = KDIM * KDIM;
   localparam int KW    = $clog2(KDIM);
   localparam int KAW   = $clog2(TAPS);
   localparam int PDEP  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(PDEP);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int ACC_W = gbr_pkg::PROD_W + $clog2(TAPS);
   localparam int SUM_W = gbr_pkg::WGT_W + $clog2(TAPS);

   // configuration registers
   logic [gbr_pkg::DIM_W-1:0] frame_width_ff;
   logic [gbr_pkg::DIM_W-1:0] frame_height_ff;
   logic [gbr_pkg::RAD_W-1:0] kernel_radius_ff;
   logic                      csr_wr;

   // sequencer
   gbr_pkg::gbr_state_type state_ff, state_in;
   logic req_fire, scan_start, issue, div_start, res_we, rsp_load;
   logic k_wr_en, p_wr_en;
   logic [gbr_pkg::PIX_W-1:0] res_val;

   // effective configuration
   logic [gbr_pkg::DIM_W-1:0] w_eff, h_eff;
   logic [RW-1:0]             r_eff;
   logic [KW-1:0]             span;

   // scan state
   logic [gbr_pkg::POS_W-1:0] cx_ff, cy_ff;
   logic [KW-1:0]             dx_ff, dy_ff;
   logic                      any_skip_ff;
   logic signed [9:0]         px, py;
   logic                      in_frame;
   logic [AW-1:0]             pix_rd_addr, pix_wr_addr;
   logic [KAW-1:0]            k_rd_addr, k_wr_addr;
   logic                      k_in_range, p_in_range, outside;

   // tap pipeline
   logic                        s1_vld_ff, s1_in_ff, s2_vld_ff;
   logic [gbr_pkg::PIX_W-1:0]   pix_rd_data;
   logic [gbr_pkg::WGT_W-1:0]   k_rd_data;
   logic [gbr_pkg::PROD_W-1:0]  prod_ff;
   logic [gbr_pkg::WGT_W-1:0]   kw_ff;
   logic [ACC_W-1:0]            acc_ff;
   logic [SUM_W-1:0]            wsum_ff;
   logic [gbr_pkg::PIX_W-1:0]   sat_interior;

   // divider and result
   logic                      div_done;
   logic [gbr_pkg::PIX_W-1:0] div_quot;
   logic [gbr_pkg::PIX_W-1:0] res_ff;
   logic                      rsp_valid_ff;
   logic [gbr_pkg::PIX_W-1:0] rsp_data_ff;

   // register write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= gbr_pkg::FRAME_WIDTH_RST;
         frame_height_ff  <= gbr_pkg::FRAME_HEIGHT_RST;
         kernel_radius_ff <= gbr_pkg::RADIUS_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            gbr_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[gbr_pkg::DIM_W-1:0];
            gbr_pkg::CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[gbr_pkg::DIM_W-1:0];
            gbr_pkg::CSR_KERNEL_RADIUS: kernel_radius_ff <= csr_pwdata[gbr_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         gbr_pkg::CSR_FRAME_WIDTH:   csr_prdata = gbr_pkg::CSR_DW'(frame_width_ff);
         gbr_pkg::CSR_FRAME_HEIGHT:  csr_prdata = gbr_pkg::CSR_DW'(frame_height_ff);
         gbr_pkg::CSR_KERNEL_RADIUS: csr_prdata = gbr_pkg::CSR_DW'(kernel_radius_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // clamp registers into their legal ranges
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = 9'd1;
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = gbr_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = 9'd1;
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = gbr_pkg::DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
      if (kernel_radius_ff == '0) begin
         r_eff = RW'(1);
      end else if (32'(kernel_radius_ff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(kernel_radius_ff);
      end
   end

   assign span = KW'(2 * r_eff);

   // load decode
   assign req_fire    = req_chan.valid & req_chan.ready;
   assign k_in_range  = (32'(req_chan.pos_x) < KDIM) && (32'(req_chan.pos_y) < KDIM);
   assign p_in_range  = (32'(req_chan.pos_x) < MAX_WIDTH) && (32'(req_chan.pos_y) < MAX_HEIGHT);
   assign k_wr_addr   = KAW'(32'(req_chan.pos_y) * KDIM + 32'(req_chan.pos_x));
   assign pix_wr_addr = AW'(32'(req_chan.pos_y) * MAX_WIDTH + 32'(req_chan.pos_x));
   assign outside     = ({1'b0, req_chan.pos_x} >= w_eff) || ({1'b0, req_chan.pos_y} >= h_eff);

   // current tap position
   assign px = $signed({2'b00, cx_ff}) + $signed(10'(dx_ff)) - $signed(10'(r_eff));
   assign py = $signed({2'b00, cy_ff}) + $signed(10'(dy_ff)) - $signed(10'(r_eff));
   assign in_frame = (px >= 0) && (px < $signed({1'b0, w_eff}))
                  && (py >= 0) && (py < $signed({1'b0, h_eff}));
   assign pix_rd_addr = AW'(32'(py[7:0]) * MAX_WIDTH + 32'(px[7:0]));
   assign k_rd_addr   = KAW'(32'(dy_ff) * KDIM + 32'(dx_ff));

   // interior result: Q22.16 sum shifted down, saturated
   assign sat_interior = (|acc_ff[ACC_W-1:gbr_pkg::PROD_W]) ? gbr_pkg::SAT_MAX
                                                             : acc_ff[gbr_pkg::PROD_W-1:16];

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_chan.ready = (state_ff == gbr_pkg::ST_IDLE);

   // next state and controls
   always_comb begin
      state_in   = state_ff;
      scan_start = 1'b0;
      issue      = 1'b0;
      div_start  = 1'b0;
      res_we     = 1'b0;
      res_val    = '0;
      rsp_load   = 1'b0;
      k_wr_en    = 1'b0;
      p_wr_en    = 1'b0;
      case (state_ff)
         gbr_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.req_type)
                  gbr_pkg::REQ_LOAD_WEIGHT: k_wr_en = k_in_range;
                  gbr_pkg::REQ_LOAD_PIXEL:  p_wr_en = p_in_range;
                  gbr_pkg::REQ_COMPUTE: begin
                     if (outside) begin
                        res_we   = 1'b1;
                        state_in = gbr_pkg::ST_FINISH;
                     end else begin
                        scan_start = 1'b1;
                        state_in   = gbr_pkg::ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         gbr_pkg::ST_SCAN: begin
            issue = 1'b1;
            if (dx_ff == span && dy_ff == span) begin
               state_in = gbr_pkg::ST_DRAIN;
            end
         end
         gbr_pkg::ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               if (!any_skip_ff) begin
                  res_we   = 1'b1;
                  res_val  = sat_interior;
                  state_in = gbr_pkg::ST_FINISH;
               end else if (wsum_ff == '0) begin
                  res_we   = 1'b1;
                  state_in = gbr_pkg::ST_FINISH;
               end else begin
                  div_start = 1'b1;
                  state_in  = gbr_pkg::ST_DIVIDE;
               end
            end
         end
         gbr_pkg::ST_DIVIDE: begin
            if (div_done) begin
               res_we   = 1'b1;
               res_val  = div_quot;
               state_in = gbr_pkg::ST_FINISH;
            end
         end
         gbr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = gbr_pkg::ST_IDLE;
            end
         end
         default: state_in = gbr_pkg::ST_IDLE;
      endcase
   end

   // tap counters and border flag
   always_ff @(posedge clock) begin
      if (reset) begin
         dx_ff       <= '0;
         dy_ff       <= '0;
         any_skip_ff <= 1'b0;
      end else if (scan_start) begin
         dx_ff       <= '0;
         dy_ff       <= '0;
         any_skip_ff <= 1'b0;
      end else if (issue) begin
         if (!in_frame) begin
            any_skip_ff <= 1'b1;
         end
         if (dx_ff == span) begin
            dx_ff <= '0;
            dy_ff <= dy_ff + 1'b1;
         end else begin
            dx_ff <= dx_ff + 1'b1;
         end
      end
   end

   // requested coordinate
   always_ff @(posedge clock) begin
      if (scan_start) begin
         cx_ff <= req_chan.pos_x;
         cy_ff <= req_chan.pos_y;
      end
   end

   // memories
   gbr_pixel_mem #(
      .DEPTH (PDEP),
      .AW    (AW)
   ) u_pixel_mem (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (pix_wr_addr),
      .wr_data (req_chan.value),
      .rd_en   (issue & in_frame),
      .rd_addr (pix_rd_addr),
      .rd_data (pix_rd_data)
   );

   gbr_kernel_mem #(
      .DEPTH (TAPS),
      .AW    (KAW)
   ) u_kernel_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (k_wr_en),
      .wr_addr (k_wr_addr),
      .wr_data (req_chan.value),
      .rd_en   (issue),
      .rd_addr (k_rd_addr),
      .rd_data (k_rd_data)
   );

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s1_in_ff  <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s1_in_ff  <= issue & in_frame;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // multiply stage, off-frame taps contribute nothing
   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         prod_ff <= s1_in_ff ? k_rd_data * pix_rd_data : '0;
         kw_ff   <= s1_in_ff ? k_rd_data : '0;
      end
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (scan_start) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff  <= acc_ff + ACC_W'(prod_ff);
         wsum_ff <= wsum_ff + SUM_W'(kw_ff);
      end
   end

   // border renormalization
   gbr_divider #(
      .ACC_W (ACC_W),
      .SUM_W (SUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (wsum_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // result holding register
   always_ff @(posedge clock) begin
      if (res_we) begin
         res_ff <= res_val;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_pixel = rsp_data_ff;

`ifndef SYNTHESIS
   // tap pipeline is empty whenever a new transaction can be taken
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbr_pkg::ST_IDLE) |-> !(s1_vld_ff || s2_vld_ff))
      else $error("tap pipeline busy in idle");

   // divider finishes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == gbr_pkg::ST_DIVIDE))
      else $error("divider done outside divide state");

   // a new result appears only after the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == gbr_pkg::ST_FINISH))
      else $error("result loaded outside finish state");

   // tap counters stay inside the kernel window
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbr_pkg::ST_SCAN) |-> ((dx_ff <= span) && (dy_ff <= span)))
      else $error("tap counter beyond kernel window");
`endif

endmodule

`default_nettype wire
